### rtl/core/utf8v_pkg.sv
package utf8v_pkg;

    localparam int DATA_W    = 8;
    localparam int LEN_W     = 16;
    localparam int POINT_W   = 21;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH = 1'b0,
        CFG_MAX_LENGTH = 1'b1
    } t_cfg_idx;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 16'd15;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'd128;

    // Class of the open sequence, sets the least legal code point
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_2BYTE = 2'd1,
        CLS_3BYTE = 2'd2,
        CLS_4BYTE = 2'd3
    } t_cls;

    localparam logic [DATA_W-1:0] CTRL_LIMIT = 8'h20;
    localparam logic [DATA_W-1:0] DEL_BYTE   = 8'h7f;
    localparam logic [DATA_W-1:0] ASCII_END  = 8'h80;
    localparam logic [DATA_W-1:0] LEAD2_LO   = 8'hc2;
    localparam logic [DATA_W-1:0] LEAD2_HI   = 8'hdf;
    localparam logic [DATA_W-1:0] LEAD3_LO   = 8'he0;
    localparam logic [DATA_W-1:0] LEAD3_HI   = 8'hef;
    localparam logic [DATA_W-1:0] LEAD4_LO   = 8'hf0;
    localparam logic [DATA_W-1:0] LEAD4_HI   = 8'hf4;
    localparam logic [1:0]        CONT_TAG   = 2'b10;

    localparam logic [POINT_W-1:0] POINT_MAX = 21'h10ffff;
    localparam logic [POINT_W-1:0] SURR_LO   = 21'h00d800;
    localparam logic [POINT_W-1:0] SURR_HI   = 21'h00dfff;
    localparam logic [POINT_W-1:0] MIN_2B    = 21'h000080;
    localparam logic [POINT_W-1:0] MIN_3B    = 21'h000800;
    localparam logic [POINT_W-1:0] MIN_4B    = 21'h010000;

    // Decoder status handed to the result stage
    typedef struct packed {
        logic ok;        // no error and no sequence left open
        logic overflow;  // count stuck at its maximum
    } t_text_status;

    function automatic logic [POINT_W-1:0] least_point(input t_cls cls);
        logic [POINT_W-1:0] v;
        case (cls)
            CLS_2BYTE: v = MIN_2B;
            CLS_3BYTE: v = MIN_3B;
            default:   v = MIN_4B;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/utf8v_in_if.sv
interface utf8v_in_if;
    logic                           valid;
    logic                           ready;
    logic [utf8v_pkg::DATA_W-1:0]   data_byte;
    logic                           is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

### rtl/core/utf8v_out_if.sv
interface utf8v_out_if;
    logic                           valid;
    logic                           ready;
    logic                           well_formed;
    logic [utf8v_pkg::LEN_W-1:0]    char_count;
    logic                           count_saturated;
    logic                           length_ok;

    modport source (output valid, output well_formed, output char_count,
                    output count_saturated, output length_ok, input ready);
    modport sink   (input valid, input well_formed, input char_count,
                    input count_saturated, input length_ok, output ready);
endinterface

### rtl/core/utf8v_decoder.sv
module utf8v_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [utf8v_pkg::DATA_W-1:0]   i_byte,
    input  logic                           i_end,
    output utf8v_pkg::t_text_status        o_status,
    output logic [COUNT_WIDTH-1:0]         o_count
);

    logic                           r_err, n_err;
    logic [1:0]                     r_pending, n_pending;
    logic [utf8v_pkg::POINT_W-1:0]  r_partial, n_partial;
    utf8v_pkg::t_cls                r_cls, n_cls;
    logic [COUNT_WIDTH-1:0]         r_count, n_count;
    logic                           r_ovf, n_ovf;

    logic [utf8v_pkg::POINT_W-1:0]  shifted;
    logic                           bad_point;
    logic                           bump;

    assign shifted = {r_partial[utf8v_pkg::POINT_W-7:0], i_byte[5:0]};
    assign bad_point = (shifted < utf8v_pkg::least_point(r_cls))
                    || (shifted > utf8v_pkg::POINT_MAX)
                    || ((shifted >= utf8v_pkg::SURR_LO) && (shifted <= utf8v_pkg::SURR_HI));

    always_comb begin
        n_err     = r_err;
        n_pending = r_pending;
        n_partial = r_partial;
        n_cls     = r_cls;
        bump      = 1'b0;
        if (i_step && !i_end && !r_err) begin
            if (r_pending == 2'd0) begin
                if ((i_byte < utf8v_pkg::CTRL_LIMIT) || (i_byte == utf8v_pkg::DEL_BYTE)) begin
                    n_err = 1'b1;
                end else if (i_byte < utf8v_pkg::ASCII_END) begin
                    bump = 1'b1;
                end else if (i_byte inside {[utf8v_pkg::LEAD2_LO:utf8v_pkg::LEAD2_HI]}) begin
                    n_partial = utf8v_pkg::POINT_W'(i_byte[4:0]);
                    n_pending = 2'd1;
                    n_cls     = utf8v_pkg::CLS_2BYTE;
                end else if (i_byte inside {[utf8v_pkg::LEAD3_LO:utf8v_pkg::LEAD3_HI]}) begin
                    n_partial = utf8v_pkg::POINT_W'(i_byte[3:0]);
                    n_pending = 2'd2;
                    n_cls     = utf8v_pkg::CLS_3BYTE;
                end else if (i_byte inside {[utf8v_pkg::LEAD4_LO:utf8v_pkg::LEAD4_HI]}) begin
                    n_partial = utf8v_pkg::POINT_W'(i_byte[2:0]);
                    n_pending = 2'd3;
                    n_cls     = utf8v_pkg::CLS_4BYTE;
                end else begin
                    n_err = 1'b1;
                end
            end else if (i_byte[7:6] != utf8v_pkg::CONT_TAG) begin
                n_err = 1'b1;
            end else if (r_pending == 2'd1) begin
                // last continuation: check range, then count
                if (bad_point) begin
                    n_err = 1'b1;
                end else begin
                    bump = 1'b1;
                end
                n_pending = 2'd0;
                n_partial = '0;
                n_cls     = utf8v_pkg::CLS_NONE;
            end else begin
                n_partial = shifted;
                n_pending = r_pending - 2'd1;
            end
            if (n_err) begin
                n_pending = 2'd0;
                n_partial = '0;
                n_cls     = utf8v_pkg::CLS_NONE;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (bump) begin
            if (r_count == {COUNT_WIDTH{1'b1}}) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_err     <= 1'b0;
            r_pending <= 2'd0;
            r_partial <= '0;
            r_cls     <= utf8v_pkg::CLS_NONE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_err     <= n_err;
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_cls     <= n_cls;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
        end
    end

    assign o_status.ok       = !r_err && (r_pending == 2'd0);
    assign o_status.overflow = r_ovf;
    assign o_count           = r_count;

endmodule

### rtl/core/utf8v_report.sv
module utf8v_report #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  utf8v_pkg::t_text_status        i_status,
    input  logic [COUNT_WIDTH-1:0]         i_count,
    input  logic [utf8v_pkg::LEN_W-1:0]    i_min_length,
    input  logic [utf8v_pkg::LEN_W-1:0]    i_max_length,
    output logic                           o_free,
    utf8v_out_if.source                    o_out
);

    localparam int EXT_W = (COUNT_WIDTH > utf8v_pkg::LEN_W) ? COUNT_WIDTH
                                                             : utf8v_pkg::LEN_W + 1;

    logic                           r_valid;
    logic                           r_well_formed;
    logic [utf8v_pkg::LEN_W-1:0]    r_char_count;
    logic                           r_saturated;
    logic                           r_length_ok;

    logic [EXT_W-1:0]               count_ext;
    logic                           wide;
    logic                           sat;
    logic [utf8v_pkg::LEN_W-1:0]    clipped;
    logic [utf8v_pkg::LEN_W-1:0]    n_char_count;
    logic                           n_saturated;
    logic                           n_length_ok;

    assign count_ext = EXT_W'(i_count);
    assign wide      = |count_ext[EXT_W-1:utf8v_pkg::LEN_W];
    assign sat       = i_status.overflow || wide;
    assign clipped   = wide ? {utf8v_pkg::LEN_W{1'b1}} : count_ext[utf8v_pkg::LEN_W-1:0];

    // Invalid text reports zeros
    assign n_char_count = i_status.ok ? clipped : '0;
    assign n_saturated  = i_status.ok && sat;
    assign n_length_ok  = i_status.ok && !sat
                       && (clipped >= i_min_length) && (clipped <= i_max_length);

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_well_formed <= i_status.ok;
            r_char_count  <= n_char_count;
            r_saturated   <= n_saturated;
            r_length_ok   <= n_length_ok;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.well_formed     = r_well_formed;
    assign o_out.char_count      = r_char_count;
    assign o_out.count_saturated = r_saturated;
    assign o_out.length_ok       = r_length_ok;

endmodule

### rtl/core/utf8_validate_count_core.sv
// Channel  | Dir | Payload                                         | Per request
// ---------+-----+-------------------------------------------------+-----------------------
// i_in     | in  | data_byte[7:0], is_end                          | one byte or end marker
// o_out    | out | well_formed, char_count[15:0], count_saturated, | one per end marker
//          |     | length_ok                                       |
// i_cfg_*  | in  | i_cfg_index, i_cfg_data[15:0]                   | write min/max length
//
// Throughput is one request per cycle unless an end request waits on a stalled result;
// the decode state update is a few gates between the input register and the decoder
// state registers. Results are registered as end requests leave the input register.
// Reset is synchronous, active low; it empties both stages and restores the bounds.
// A stalled result holds the next end request in the input register, which then
// back-pressures i_in; until then, byte requests keep flowing while a result waits.
module utf8_validate_count_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    utf8v_in_if.sink                           i_in,
    utf8v_out_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [utf8v_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [utf8v_pkg::LEN_W-1:0]        i_cfg_data
);

    // Length bounds
    logic [utf8v_pkg::LEN_W-1:0]    r_min_length;
    logic [utf8v_pkg::LEN_W-1:0]    r_max_length;

    // Input register
    logic                           r_in_valid;
    logic [utf8v_pkg::DATA_W-1:0]   r_in_byte;
    logic                           r_in_end;

    utf8v_pkg::t_text_status        status;
    logic [COUNT_WIDTH-1:0]         count;
    logic                           out_free;
    logic                           advance;
    logic                           take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= utf8v_pkg::MIN_LENGTH_RST;
            r_max_length <= utf8v_pkg::MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (utf8v_pkg::t_cfg_idx'(i_cfg_index))
                utf8v_pkg::CFG_MIN_LENGTH: r_min_length <= i_cfg_data;
                utf8v_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance a byte always; advance an end request only when the result
    // register can take its result.
    assign advance    = r_in_valid && (!r_in_end || out_free);
    assign i_in.ready = !r_in_valid || advance;
    assign take       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.is_end;
        end
    end

    utf8v_decoder #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_status (status),
        .o_count  (count)
    );

    // Capture the result from the decoder state as it stands before the clear
    utf8v_report #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_report (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && r_in_end),
        .i_status     (status),
        .i_count      (count),
        .i_min_length (r_min_length),
        .i_max_length (r_max_length),
        .o_free       (out_free),
        .o_out        (o_out)
    );

endmodule

### rtl/core/utf8v_checker.sv
module utf8v_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic         i_well_formed,
    input logic [15:0]  i_char_count,
    input logic         i_count_saturated,
    input logic         i_length_ok
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Invalid text reports zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_well_formed |->
            (i_char_count == 16'd0) && !i_count_saturated && !i_length_ok)
        else $error("invalid text with nonzero fields");

    // Length check needs a valid, unsaturated count
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_length_ok |-> i_well_formed && !i_count_saturated)
        else $error("length_ok without valid count");

    // Saturated count reads as all ones
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count_saturated |-> (i_char_count == 16'hffff))
        else $error("saturated count below maximum");

    // Drop the result on reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result present after reset");

endmodule

bind utf8_validate_count_core utf8v_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_well_formed     (o_out.well_formed),
    .i_char_count      (o_out.char_count),
    .i_count_saturated (o_out.count_saturated),
    .i_length_ok       (o_out.length_ok)
);
